// ===== hw/rtl/tracked_id_table_core_assert.svh =====
// Assertion macros for the tracked id table. They expect clk and rst_n in scope.
`ifndef TRACKED_ID_TABLE_CORE_ASSERT_SVH
`define TRACKED_ID_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TIT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TIT_ASSERT_SAME(label, ante, cons, msg)
`define TIT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/tit_pkg.sv =====
package tit_pkg;

  localparam int KEY_W  = 32;
  localparam int PAGE_W = 64;

  typedef enum logic [2:0] {
    ACT_ADD       = 3'd0,
    ACT_REMOVE    = 3'd1,
    ACT_UNTRACK   = 3'd2,
    ACT_SUSPEND   = 3'd3,
    ACT_SET_PAGE  = 3'd4,
    ACT_SET_FIRST = 3'd5,
    ACT_QUERY     = 3'd6,
    ACT_GET_ANY   = 3'd7
  } act_t;

  typedef struct packed {
    act_t              action;
    logic [KEY_W-1:0]  key_id;
    logic [PAGE_W-1:0] page_value;
    logic              first_flag_value;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic              tracked_out;
    logic              suspended_out;
    logic [PAGE_W-1:0] page_out;
    logic              first_flag_out;
    logic [KEY_W-1:0]  id_out;
  } rsp_t;

endpackage

// ===== hw/rtl/tit_slot_array.sv =====
module tit_slot_array #(
  parameter int SLOT_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          op_en,
  input  tit_pkg::req_t req,
  output tit_pkg::rsp_t rsp
);

  logic [SLOT_COUNT-1:0]         valid_r, valid_nxt;
  logic [SLOT_COUNT-1:0]         first_r, first_nxt;
  logic [SLOT_COUNT-1:0]         susp_r, susp_nxt;
  logic [SLOT_COUNT-1:0]         trk_r, trk_nxt;
  logic [tit_pkg::KEY_W-1:0]     key_r [SLOT_COUNT];
  logic [tit_pkg::KEY_W-1:0]     key_nxt [SLOT_COUNT];
  logic [tit_pkg::PAGE_W-1:0]    page_r [SLOT_COUNT];
  logic [tit_pkg::PAGE_W-1:0]    page_nxt [SLOT_COUNT];

  logic [SLOT_COUNT-1:0]         hit;
  logic [SLOT_COUNT-1:0]         free;
  logic [SLOT_COUNT-1:0]         add_sel;
  logic [SLOT_COUNT-1:0]         hi_hit;
  logic [SLOT_COUNT-1:0]         hi_valid;
  logic                          q_trk, q_susp, q_first;
  logic [tit_pkg::PAGE_W-1:0]    q_page;
  logic [tit_pkg::KEY_W-1:0]     q_id;

  assign free    = ~valid_r;
  assign add_sel = free & (~free + {{(SLOT_COUNT-1){1'b0}}, 1'b1});

  always_comb begin
    logic seen_h;
    logic seen_v;
    seen_h = 1'b0;
    seen_v = 1'b0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      hit[s]      = valid_r[s] && (key_r[s] == req.key_id);
      hi_hit[s]   = hit[s] && !seen_h;
      hi_valid[s] = valid_r[s] && !seen_v;
      seen_h      = seen_h | hit[s];
      seen_v      = seen_v | valid_r[s];
    end
  end

  always_comb begin
    q_trk   = 1'b0;
    q_susp  = 1'b0;
    q_first = 1'b0;
    q_page  = '0;
    q_id    = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      q_trk   = q_trk | (hi_hit[s] & trk_r[s]);
      q_susp  = q_susp | (hi_hit[s] & susp_r[s]);
      q_first = q_first | (hi_hit[s] & first_r[s]);
      q_page  = q_page | ({tit_pkg::PAGE_W{hi_hit[s]}} & page_r[s]);
      q_id    = q_id | ({tit_pkg::KEY_W{hi_valid[s]}} & key_r[s]);
    end
  end

  always_comb begin
    rsp = '0;
    case (req.action)
      tit_pkg::ACT_ADD: begin
        rsp.ok = |free;
      end
      tit_pkg::ACT_GET_ANY: begin
        rsp.ok     = |valid_r;
        rsp.id_out = q_id;
      end
      tit_pkg::ACT_QUERY: begin
        rsp.ok             = |hit;
        rsp.tracked_out    = q_trk;
        rsp.suspended_out  = q_susp;
        rsp.page_out       = q_page;
        rsp.first_flag_out = q_first;
      end
      default: begin
        rsp.ok = |hit;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    first_nxt = first_r;
    susp_nxt  = susp_r;
    trk_nxt   = trk_r;
    key_nxt   = key_r;
    page_nxt  = page_r;
    if (op_en) begin
      for (int s = 0; s < SLOT_COUNT; s++) begin
        case (req.action)
          tit_pkg::ACT_ADD: begin
            if (add_sel[s]) begin
              valid_nxt[s] = 1'b1;
              key_nxt[s]   = req.key_id;
              trk_nxt[s]   = 1'b1;
            end
          end
          tit_pkg::ACT_REMOVE: begin
            if (hit[s]) begin
              valid_nxt[s] = 1'b0;
              key_nxt[s]   = '0;
              page_nxt[s]  = '0;
              first_nxt[s] = 1'b1;
              susp_nxt[s]  = 1'b0;
              trk_nxt[s]   = 1'b0;
            end
          end
          tit_pkg::ACT_UNTRACK: begin
            if (hit[s]) begin
              trk_nxt[s] = 1'b0;
            end
          end
          tit_pkg::ACT_SUSPEND: begin
            if (hit[s]) begin
              susp_nxt[s] = 1'b1;
            end
          end
          tit_pkg::ACT_SET_PAGE: begin
            if (hit[s]) begin
              page_nxt[s] = req.page_value;
            end
          end
          tit_pkg::ACT_SET_FIRST: begin
            if (hit[s]) begin
              first_nxt[s] = req.first_flag_value;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      first_r <= '1;
      susp_r  <= '0;
      trk_r   <= '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        key_r[s]  <= '0;
        page_r[s] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      first_r <= first_nxt;
      susp_r  <= susp_nxt;
      trk_r   <= trk_nxt;
      key_r   <= key_nxt;
      page_r  <= page_nxt;
    end
  end

endmodule

// ===== hw/rtl/tracked_id_table_core.sv =====
// Channel  Direction  Ports                       Contents
// in       slave      in_tvalid/tready/tdata/tuser  one table action with its operands
// out      master     out_tvalid/tready/tdata       one result per action
//
// One transfer is taken per cycle while the output is not stalled.
// The table is read and updated as a transfer moves from input to result register.
// Reset returns every slot to its empty state.
// A stalled output holds its result, and the input stage keeps one more transfer.
`include "tracked_id_table_core_assert.svh"

module tracked_id_table_core #(
  parameter int SLOT_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // key_id[31:0], page_value[95:32], first_flag_value[96], zero fill above.
  input  logic [103:0] in_tdata,
  // action[2:0].
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // ok[0], tracked_out[1], suspended_out[2], page_out[66:3], first_flag_out[67],
  // id_out[99:68], zero fill above.
  output logic [103:0] out_tdata
);

  logic          in_v_r, in_v_nxt;
  tit_pkg::req_t req_r, req_nxt;
  logic          out_v_r, out_v_nxt;
  tit_pkg::rsp_t rsp_r, rsp_nxt;
  tit_pkg::rsp_t rsp;
  logic          adv;
  logic          out_stall;
  logic          rsp_blank;

  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  tit_slot_array #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .op_en (adv),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_comb begin
    in_v_nxt  = in_v_r;
    req_nxt   = req_r;
    out_v_nxt = out_v_r;
    rsp_nxt   = rsp_r;
    if (in_tvalid && in_tready) begin
      in_v_nxt                 = 1'b1;
      req_nxt.action           = tit_pkg::act_t'(in_tuser);
      req_nxt.key_id           = in_tdata[31:0];
      req_nxt.page_value       = in_tdata[95:32];
      req_nxt.first_flag_value = in_tdata[96];
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
    if (adv) begin
      out_v_nxt = 1'b1;
      rsp_nxt   = rsp;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, rsp_r.id_out, rsp_r.first_flag_out, rsp_r.page_out,
                       rsp_r.suspended_out, rsp_r.tracked_out, rsp_r.ok};

  assign out_stall = out_v_r && !out_tready;
  assign rsp_blank = (rsp_r.page_out == '0) && (rsp_r.id_out == '0) && !rsp_r.tracked_out
                     && !rsp_r.suspended_out && !rsp_r.first_flag_out;

  `TIT_ASSERT_NEXT(a_out_hold, out_stall, out_v_r && $stable(rsp_r), "stalled result changed")
  `TIT_ASSERT_NEXT(a_req_hold, in_v_r && !adv, in_v_r && $stable(req_r), "waiting transfer lost")
  `TIT_ASSERT_SAME(a_miss_zero, out_v_r && !rsp_r.ok, rsp_blank, "failed result carries data")

endmodule

// ===== tb/sv/id_table_checker.sv =====
module id_table_checker
  import tit_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [103:0] out_tdata,
  output int           mismatch_count,
  output int           results_due
);

  logic              slot_live    [SLOT_COUNT];
  logic [KEY_W-1:0]  slot_id      [SLOT_COUNT];
  logic [PAGE_W-1:0] slot_page    [SLOT_COUNT];
  logic              slot_first   [SLOT_COUNT];
  logic              slot_susp    [SLOT_COUNT];
  logic              slot_tracked [SLOT_COUNT];

  rsp_t due_results[$];

  function automatic void empty_slot(int s);
    slot_live[s]    = 1'b0;
    slot_id[s]      = '0;
    slot_page[s]    = '0;
    slot_first[s]   = 1'b1;
    slot_susp[s]    = 1'b0;
    slot_tracked[s] = 1'b0;
  endfunction

  // Updates the table for one action and returns the result it produces.
  function automatic rsp_t apply_table_action(req_t r);
    rsp_t q;
    bit   found;
    q = '0;
    found = 1'b0;
    case (r.action)
      ACT_ADD: begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (!found && !slot_live[s]) begin
            slot_live[s]    = 1'b1;
            slot_id[s]      = r.key_id;
            slot_tracked[s] = 1'b1;
            found = 1'b1;
          end
        end
      end
      ACT_GET_ANY: begin
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
          if (!found && slot_live[s]) begin
            q.id_out = slot_id[s];
            found = 1'b1;
          end
        end
      end
      ACT_QUERY: begin
        for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
          if (!found && slot_live[s] && slot_id[s] == r.key_id) begin
            q.tracked_out    = slot_tracked[s];
            q.suspended_out  = slot_susp[s];
            q.page_out       = slot_page[s];
            q.first_flag_out = slot_first[s];
            found = 1'b1;
          end
        end
      end
      default: begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
          if (slot_live[s] && slot_id[s] == r.key_id) begin
            found = 1'b1;
            case (r.action)
              ACT_REMOVE:   empty_slot(s);
              ACT_UNTRACK:  slot_tracked[s] = 1'b0;
              ACT_SUSPEND:  slot_susp[s] = 1'b1;
              ACT_SET_PAGE: slot_page[s] = r.page_value;
              default:      slot_first[s] = r.first_flag_value;
            endcase
          end
        end
      end
    endcase
    q.ok = found;
    return q;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    rsp_t got;
    req_t req;
    if (!rst_n) begin
      for (int s = 0; s < SLOT_COUNT; s++) empty_slot(s);
      due_results.delete();
      results_due = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.ok             = out_tdata[0];
        got.tracked_out    = out_tdata[1];
        got.suspended_out  = out_tdata[2];
        got.page_out       = out_tdata[66:3];
        got.first_flag_out = out_tdata[67];
        got.id_out         = out_tdata[99:68];
        if (due_results.size() == 0) begin
          $display("%0t: result transfer with none expected, actual %0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("ok", want.ok, got.ok);
          check_field("tracked_out", want.tracked_out, got.tracked_out);
          check_field("suspended_out", want.suspended_out, got.suspended_out);
          check_field("page_out", want.page_out, got.page_out);
          check_field("first_flag_out", want.first_flag_out, got.first_flag_out);
          check_field("id_out", want.id_out, got.id_out);
        end
      end
      if (in_tvalid && in_tready) begin
        req.action           = act_t'(in_tuser);
        req.key_id           = in_tdata[31:0];
        req.page_value       = in_tdata[95:32];
        req.first_flag_value = in_tdata[96];
        due_results.push_back(apply_table_action(req));
      end
      results_due = due_results.size();
    end
  end

endmodule

// ===== tb/sv/tracked_id_table_core_tb.sv =====
module tracked_id_table_core_tb;
  import tit_pkg::*;

  localparam int SLOTS = 8;
  localparam int POOL_SIZE = 10;
  localparam int PHASE_ITEMS = 120;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 60;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic [2:0]   in_tuser = ACT_GET_ANY;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  int mismatch_count;
  int results_due;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  logic long_hold_req = 1'b0;
  logic hold_served = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  tracked_id_table_core #(.SLOT_COUNT(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  id_table_checker #(.SLOT_COUNT(SLOTS)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A long hold-off is served once per request, then normal random stalling resumes.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_served) begin
      out_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_served <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
      if (!long_hold_req) hold_served <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tracked_id_table_core_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send(act_t act, logic [31:0] key, logic [63:0] page, logic first);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {7'd0, first, page, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_results_in;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  function automatic act_t pick_action();
    int r;
    r = $urandom_range(99);
    if (r < 25) return ACT_ADD;
    if (r < 38) return ACT_REMOVE;
    if (r < 46) return ACT_UNTRACK;
    if (r < 54) return ACT_SUSPEND;
    if (r < 64) return ACT_SET_PAGE;
    if (r < 72) return ACT_SET_FIRST;
    if (r < 90) return ACT_QUERY;
    return ACT_GET_ANY;
  endfunction

  initial begin
    logic [31:0] key_pool [POOL_SIZE];
    int tx_plan [5];
    int rx_plan [5];
    logic [31:0] key;
    tx_plan = '{0, 72, 0, 25, 0};
    rx_plan = '{0, 0, 72, 25, 0};
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: nothing matches, not even the zero key held by free slots.
    send(ACT_GET_ANY, 32'h0, 64'h0, 1'b0);
    send(ACT_QUERY, 32'h0, 64'h0, 1'b0);
    send(ACT_REMOVE, 32'h0, 64'h0, 1'b0);
    send(ACT_ADD, 32'h0, 64'h0, 1'b0);
    send(ACT_ADD, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_ADD, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_SET_PAGE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send(ACT_SET_FIRST, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_SUSPEND, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_UNTRACK, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_QUERY, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_QUERY, 32'h0, 64'h0, 1'b0);
    send(ACT_GET_ANY, 32'h0, 64'h0, 1'b0);
    for (int i = 1; i <= 5; i++) send(ACT_ADD, i, 64'h0, 1'b0);
    send(ACT_GET_ANY, 32'h0, 64'h0, 1'b0);
    // The table is full now, so this add must fail.
    send(ACT_ADD, 32'h8000_0000, 64'h0, 1'b0);
    send(ACT_REMOVE, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_QUERY, 32'hFFFF_FFFF, 64'h0, 1'b0);
    send(ACT_SET_PAGE, 32'h0, 64'h0, 1'b0);
    send(ACT_SET_FIRST, 32'h0, 64'h0, 1'b1);
    send(ACT_QUERY, 32'h0, 64'h0, 1'b0);
    wait_results_in();

    for (int p = 0; p < 5; p++) begin
      tx_idle_pct = tx_plan[p];
      rx_stall_pct <= rx_plan[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 40) long_hold_req <= 1'b1;
        if (p == 0 && n == 70) long_hold_req <= 1'b0;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else key = $urandom;
        send(pick_action(), key, {$urandom, $urandom}, 1'($urandom_range(1)));
      end
      wait_results_in();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tracked_id_table_core_tb: done, clean");
    end else begin
      $display("tracked_id_table_core_tb: done, errors");
    end
    $finish;
  end

endmodule
